FILE: src/lvfe_pkg.sv
// ----------------------------------------------------------------------------
// lvfe_pkg
// shared types, constants and helpers of the lattice voter flip engine
// ----------------------------------------------------------------------------
package lvfe_pkg;

    localparam int MAX_SIDE = 64;
    localparam int POS_W    = $clog2(MAX_SIDE);
    localparam int SIDE_W   = 7;
    localparam int ADDR_W   = 2 * POS_W;
    localparam int TOTAL_W  = 13;
    localparam int RCNT_W   = POS_W + 1;
    localparam int NCNT_W   = 3;
    localparam int ENT_W    = NCNT_W + 1;

    localparam logic [SIDE_W-1:0]  SIDE_MIN   = 7'd3;
    localparam logic [SIDE_W-1:0]  SIDE_MAX   = SIDE_W'(MAX_SIDE);
    localparam logic [SIDE_W-1:0]  SIDE_RESET = 7'd32;
    localparam logic [TOTAL_W-1:0] SEED_ACTIVE   = 13'd5;
    localparam logic [TOTAL_W-1:0] SEED_OCCUPIED = 13'd1;
    localparam logic [NCNT_W-1:0]  NCNT_FULL     = 3'd4;

    localparam logic REG_GRID_SIDE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ROWSCAN,
        ST_COLSCAN,
        ST_UPD_RD,
        ST_UPD_CELL,
        ST_UPD_ROW,
        ST_DONE
    } state_t;

    // one cell entry: up flag above the up-neighbor count
    typedef struct packed {
        logic              up;
        logic [NCNT_W-1:0] ncnt;
    } entry_t;

    function automatic logic [SIDE_W-1:0] side_clamp(input logic [SIDE_W-1:0] s);
        if (s < SIDE_MIN)
            return SIDE_MIN;
        else if (s > SIDE_MAX)
            return SIDE_MAX;
        else
            return s;
    endfunction

    function automatic logic ent_active(input entry_t e);
        return e.up | (e.ncnt != '0);
    endfunction

endpackage

FILE: src/lattice_voter_flip_engine.sv
// ----------------------------------------------------------------------------
// lattice_voter_flip_engine
// contact-process flip engine over a square torus of up/down cells
// ----------------------------------------------------------------------------
// A flip beat finds the pick_index-th active cell by walking a per-row
// active-count memory (one row a cycle, at most n rows for side n), then one
// row of the cell memory (at most n cells), then, if the cell changes value,
// does five read-modify-writes of the cell and row-count memories, each a
// read, a cell write and a row-count write. A bad pick goes straight to the
// result. Restart and a write of grid_side sweep the cell memory one entry a
// cycle, during which no beat is accepted; after reset the same sweep runs
// over the n*n entries of the reset side of 32.
// One result beat waits in an output register while the next beat is taken.
module lattice_voter_flip_engine
    import lvfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pick_index[11:0], draw[14:12], zero[15]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // cell_row[5:0], cell_col[11:6], new_value[12],
                                   // active_total[25:13], occupied_total[38:26],
                                   // now_empty[39]
    output logic        m_tuser    // bad_pick
);

    state_t state_reg, state_next;
    logic [SIDE_W-1:0]  side_reg, side_next;
    logic [TOTAL_W-1:0] act_reg, act_next, occ_reg, occ_next, seen_reg, seen_next;
    logic [POS_W-1:0]   clr_row_reg, clr_row_next, clr_col_reg, clr_col_next;
    logic               clr_item_reg, clr_item_next;
    logic [11:0]        pick_reg, pick_next;
    logic [2:0]         draw_reg, draw_next;
    logic [SIDE_W-1:0]  iss_reg, iss_next;
    logic               pend_reg, pend_next;
    logic [POS_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [POS_W-1:0]   frow_reg, frow_next, fcol_reg, fcol_next;
    logic               val_reg, val_next, bad_reg, bad_next;
    logic [2:0]         k_reg, k_next;
    logic               inc_reg, inc_next, dec_reg, dec_next;
    logic               mval_reg, mval_next;
    logic [39:0]        mdata_reg, mdata_next;
    logic               muser_reg, muser_next;

    entry_t             cell_mem [0:(1<<ADDR_W)-1];
    logic [RCNT_W-1:0]  rc_mem [0:MAX_SIDE-1];
    entry_t             cell_q, cell_wdata, new_ent;
    logic [RCNT_W-1:0]  rc_q, rc_wdata;
    logic [ADDR_W-1:0]  cell_raddr, cell_waddr;
    logic [POS_W-1:0]   rc_raddr, rc_waddr;
    logic               cell_we, rc_we;

    logic [SIDE_W-1:0]  side_n;
    logic [POS_W-1:0]   mid, n_last, trow, tcol;
    logic               cfg_wr, s_acc, load;
    logic [TOTAL_W-1:0] row_sum;
    logic               old_act, new_act;

    assign side_n = side_clamp(side_reg);
    assign mid    = side_n[POS_W:1];
    assign n_last = POS_W'(side_n - SIDE_W'(1));
    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign prdata = {{(32-SIDE_W){1'b0}}, side_reg};
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc  = s_tvalid & s_tready;
    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign row_sum  = seen_reg + TOTAL_W'(rc_q);
    assign old_act  = ent_active(cell_q);
    assign new_act  = ent_active(new_ent);

    // coordinates of the cell touched in update step k: center then neighbors
    always_comb
    begin
        trow = frow_reg;
        tcol = fcol_reg;
        case (k_reg)
            3'd1: trow = (frow_reg == n_last) ? '0 : frow_reg + POS_W'(1);
            3'd2: trow = (frow_reg == '0) ? n_last : frow_reg - POS_W'(1);
            3'd3: tcol = (fcol_reg == n_last) ? '0 : fcol_reg + POS_W'(1);
            3'd4: tcol = (fcol_reg == '0) ? n_last : fcol_reg - POS_W'(1);
            default: ;
        endcase
    end

    always_comb
    begin
        new_ent = cell_q;
        if (k_reg == 3'd0)
            new_ent.up = val_reg;
        else if (val_reg && cell_q.ncnt < NCNT_FULL)
            new_ent.ncnt = cell_q.ncnt + NCNT_W'(1);
        else if (!val_reg && cell_q.ncnt != '0)
            new_ent.ncnt = cell_q.ncnt - NCNT_W'(1);
    end

    always_comb
    begin
        state_next    = state_reg;
        side_next     = side_reg;
        act_next      = act_reg;
        occ_next      = occ_reg;
        seen_next     = seen_reg;
        clr_row_next  = clr_row_reg;
        clr_col_next  = clr_col_reg;
        clr_item_next = clr_item_reg;
        pick_next     = pick_reg;
        draw_next     = draw_reg;
        iss_next      = iss_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        frow_next     = frow_reg;
        fcol_next     = fcol_reg;
        val_next      = val_reg;
        bad_next      = bad_reg;
        k_next        = k_reg;
        inc_next      = inc_reg;
        dec_next      = dec_reg;
        mdata_next    = mdata_reg;
        muser_next    = muser_reg;
        load          = 1'b0;
        cell_raddr    = {trow, tcol};
        cell_waddr    = {trow, tcol};
        cell_wdata    = new_ent;
        cell_we       = 1'b0;
        rc_raddr      = trow;
        rc_waddr      = trow;
        rc_wdata      = rc_q;
        rc_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    pick_next = s_tdata[11:0];
                    draw_next = s_tdata[14:12];
                    bad_next  = 1'b0;
                    seen_next = '0;
                    iss_next  = '0;
                    if (s_tuser)
                    begin
                        clr_row_next  = '0;
                        clr_col_next  = '0;
                        clr_item_next = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    else if ({1'b0, s_tdata[11:0]} >= act_reg)
                    begin
                        bad_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                        state_next = ST_ROWSCAN;
                end
            end
            ST_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = {clr_row_reg, clr_col_reg};
                cell_wdata.up = (clr_row_reg == mid) && (clr_col_reg == mid);
                cell_wdata.ncnt = NCNT_W'(
                    ((clr_row_reg == mid) && ((clr_col_reg == mid + POS_W'(1)) ||
                                              (clr_col_reg == mid - POS_W'(1)))) ||
                    ((clr_col_reg == mid) && ((clr_row_reg == mid + POS_W'(1)) ||
                                              (clr_row_reg == mid - POS_W'(1)))));
                rc_we    = (clr_col_reg == '0);
                rc_waddr = clr_row_reg;
                if (clr_row_reg == mid)
                    rc_wdata = RCNT_W'(3);
                else if ((clr_row_reg == mid + POS_W'(1)) || (clr_row_reg == mid - POS_W'(1)))
                    rc_wdata = RCNT_W'(1);
                else
                    rc_wdata = '0;
                if (clr_col_reg == n_last)
                begin
                    clr_col_next = '0;
                    clr_row_next = clr_row_reg + POS_W'(1);
                    if (clr_row_reg == n_last)
                    begin
                        act_next      = SEED_ACTIVE;
                        occ_next      = SEED_OCCUPIED;
                        frow_next     = mid;
                        fcol_next     = mid;
                        val_next      = 1'b1;
                        clr_item_next = 1'b0;
                        state_next    = clr_item_reg ? ST_DONE : ST_IDLE;
                    end
                end
                else
                    clr_col_next = clr_col_reg + POS_W'(1);
            end
            ST_ROWSCAN:
            begin
                rc_raddr      = iss_reg[POS_W-1:0];
                iss_next      = iss_reg + SIDE_W'(1);
                pend_next     = 1'b1;
                pend_idx_next = iss_reg[POS_W-1:0];
                if (pend_reg)
                begin
                    if (row_sum > {1'b0, pick_reg})
                    begin
                        frow_next  = pend_idx_reg;
                        iss_next   = '0;
                        pend_next  = 1'b0;
                        state_next = ST_COLSCAN;
                    end
                    else
                    begin
                        seen_next = row_sum;
                        if (pend_idx_reg == n_last)
                        begin
                            bad_next   = 1'b1;
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_COLSCAN:
            begin
                cell_raddr    = {frow_reg, iss_reg[POS_W-1:0]};
                iss_next      = iss_reg + SIDE_W'(1);
                pend_next     = 1'b1;
                pend_idx_next = iss_reg[POS_W-1:0];
                if (pend_reg)
                begin
                    if (old_act && (seen_reg == {1'b0, pick_reg}))
                    begin
                        fcol_next = pend_idx_reg;
                        val_next  = (draw_reg > cell_q.ncnt) ? 1'b0 : 1'b1;
                        pend_next = 1'b0;
                        k_next    = '0;
                        if (cell_q.up == val_next)
                            state_next = ST_DONE;
                        else
                        begin
                            occ_next   = val_next ? occ_reg + TOTAL_W'(1)
                                                  : occ_reg - TOTAL_W'(1);
                            state_next = ST_UPD_RD;
                        end
                    end
                    else
                    begin
                        if (old_act)
                            seen_next = seen_reg + TOTAL_W'(1);
                        if (pend_idx_reg == n_last)
                        begin
                            bad_next   = 1'b1;
                            pend_next  = 1'b0;
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_UPD_RD:
                state_next = ST_UPD_CELL;
            ST_UPD_CELL:
            begin
                cell_we    = 1'b1;
                inc_next   = new_act & ~old_act;
                dec_next   = old_act & ~new_act;
                state_next = ST_UPD_ROW;
            end
            ST_UPD_ROW:
            begin
                rc_we    = 1'b1;
                rc_wdata = rc_q + RCNT_W'(inc_reg) - RCNT_W'(dec_reg);
                act_next = act_reg + TOTAL_W'(inc_reg) - TOTAL_W'(dec_reg);
                k_next   = k_reg + 3'd1;
                state_next = (k_reg == 3'd4) ? ST_DONE : ST_UPD_RD;
            end
            ST_DONE:
            begin
                if (!mval_reg || m_tready)
                begin
                    load       = 1'b1;
                    mdata_next = {(act_reg == '0), occ_reg, act_reg,
                                  val_reg & ~bad_reg,
                                  bad_reg ? {POS_W{1'b0}} : fcol_reg,
                                  bad_reg ? {POS_W{1'b0}} : frow_reg};
                    muser_next = bad_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // a side write restarts the grid at the new side
        if (cfg_wr && paddr[2] == REG_GRID_SIDE)
        begin
            side_next     = pwdata[SIDE_W-1:0];
            clr_row_next  = '0;
            clr_col_next  = '0;
            clr_item_next = 1'b0;
            state_next    = ST_CLEAR;
        end

        if (load)
            mval_next = 1'b1;
        else if (m_tready)
            mval_next = 1'b0;
        else
            mval_next = mval_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            side_reg     <= SIDE_RESET;
            act_reg      <= SEED_ACTIVE;
            occ_reg      <= SEED_OCCUPIED;
            clr_row_reg  <= '0;
            clr_col_reg  <= '0;
            clr_item_reg <= 1'b0;
            pend_reg     <= 1'b0;
            k_reg        <= '0;
            mval_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            side_reg     <= side_next;
            act_reg      <= act_next;
            occ_reg      <= occ_next;
            clr_row_reg  <= clr_row_next;
            clr_col_reg  <= clr_col_next;
            clr_item_reg <= clr_item_next;
            pend_reg     <= pend_next;
            k_reg        <= k_next;
            mval_reg     <= mval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seen_reg     <= seen_next;
        pick_reg     <= pick_next;
        draw_reg     <= draw_next;
        iss_reg      <= iss_next;
        pend_idx_reg <= pend_idx_next;
        frow_reg     <= frow_next;
        fcol_reg     <= fcol_next;
        val_reg      <= val_next;
        bad_reg      <= bad_next;
        inc_reg      <= inc_next;
        dec_reg      <= dec_next;
        mdata_reg    <= mdata_next;
        muser_reg    <= muser_next;
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[cell_waddr] <= cell_wdata;
        cell_q <= cell_mem[cell_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rc_we)
            rc_mem[rc_waddr] <= rc_wdata;
        rc_q <= rc_mem[rc_raddr];
    end

    // every up cell is active
    assert property (@(posedge clk) disable iff (!rst_n) occ_reg <= act_reg)
        else $error("occupied count exceeds active count");

    // a bad pick reports no cell
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[12:0] == '0))
        else $error("bad pick result carries a cell");

    // no beat is taken during the clearing sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("beat accepted during clear");

    // an update step follows its cell write
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD_CELL) |=> (state_reg == ST_UPD_ROW) || $past(cfg_wr))
        else $error("update sequence broken");

endmodule

FILE: verif/lattice_voter_flip_engine_tb.sv
// ----------------------------------------------------------------------------
// lattice_voter_flip_engine_tb
// self-checking bench for the contact-process flip engine
// ----------------------------------------------------------------------------
// A shadow copy of the torus grid predicts every result beat. Beats stream in
// from a queue with random gaps on both sides. The grid side is changed
// between phases, including out-of-range values that clamp. Flips mostly
// pick live cells, with bad picks, odd draws and restarts mixed in.
`timescale 1ns / 100ps

module lattice_voter_flip_engine_tb;
    import lvfe_pkg::*;

    localparam logic       OP_FLIP        = 1'b0;
    localparam logic       OP_RESTART     = 1'b1;
    localparam logic [2:0] ADDR_GRID_SIDE = 3'd0;
    localparam int         STALL_LIMIT    = 20000;
    localparam int         HOLD_CYCLES    = 400;

    typedef struct packed {
        logic        op;
        logic [11:0] pick;
        logic [2:0]  draw;
    } flip_req_t;

    typedef struct packed {
        logic        bad;
        logic        empty;
        logic [12:0] occ;
        logic [12:0] act;
        logic        val;
        logic [5:0]  col;
        logic [5:0]  row;
    } flip_res_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid, s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid, m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;

    lattice_voter_flip_engine dut (.*);

    // shadow grid
    logic [6:0]  side_reg;
    bit          grid_up [MAX_SIDE*MAX_SIDE];
    logic [2:0]  up_nbrs [MAX_SIDE*MAX_SIDE];
    int          live_cells;
    int          up_cells;

    flip_req_t   pending_reqs[$];
    flip_res_t   expected_res[$];
    int          errors;
    bit          idle_on;
    int          hold_reqs, hold_done, hold_left;
    int          quiet_cycles;

    always
    begin
        clk = 1'b1; #1;
        clk = 1'b0; #1;
    end

    function automatic int eff_side();
        if (side_reg < 7'd3) return 3;
        if (side_reg > 7'd64) return MAX_SIDE;
        return int'(side_reg);
    endfunction

    function automatic bit is_live(int idx);
        return grid_up[idx] || (up_nbrs[idx] != 3'd0);
    endfunction

    function automatic void nbr_list(int r, int c, int n, output int nb[4]);
        nb[0] = ((r + 1) % n) * MAX_SIDE + c;
        nb[1] = ((r + n - 1) % n) * MAX_SIDE + c;
        nb[2] = r * MAX_SIDE + (c + 1) % n;
        nb[3] = r * MAX_SIDE + (c + n - 1) % n;
    endfunction

    function automatic void reseed_grid();
        int n;
        int m;
        int nb[4];
        n = eff_side();
        m = n / 2;
        foreach (grid_up[i])
        begin
            grid_up[i] = 0;
            up_nbrs[i] = 3'd0;
        end
        grid_up[m*MAX_SIDE + m] = 1;
        nbr_list(m, m, n, nb);
        for (int k = 0; k < 4; k++) up_nbrs[nb[k]] = 3'd1;
        live_cells = 5;
        up_cells   = 1;
    endfunction

    function automatic flip_res_t flip_step(flip_req_t q);
        flip_res_t res;
        int n, seen, idx, pre, post;
        int nb[4];
        bit found;
        bit v;
        n = eff_side();
        res = '0;
        found = 0;
        seen = 0;
        if (q.op == OP_RESTART)
        begin
            reseed_grid();
            res.row = 6'(n / 2);
            res.col = 6'(n / 2);
            res.val = 1'b1;
        end
        else if (int'(q.pick) >= live_cells)
            res.bad = 1'b1;
        else
        begin
            for (int r = 0; r < n && !found; r++)
                for (int c = 0; c < n && !found; c++)
                    if (is_live(r*MAX_SIDE + c))
                    begin
                        if (seen == int'(q.pick))
                        begin
                            res.row = 6'(r);
                            res.col = 6'(c);
                            found = 1;
                        end
                        seen++;
                    end
            if (!found)
                res.bad = 1'b1;
            else
            begin
                idx = int'(res.row) * MAX_SIDE + int'(res.col);
                v = (q.draw > up_nbrs[idx]) ? 1'b0 : 1'b1;
                res.val = v;
                if (grid_up[idx] != v)
                begin
                    nbr_list(int'(res.row), int'(res.col), n, nb);
                    pre = is_live(idx);
                    for (int k = 0; k < 4; k++) pre += is_live(nb[k]);
                    grid_up[idx] = v;
                    for (int k = 0; k < 4; k++)
                        if (v && up_nbrs[nb[k]] < 3'd4)
                            up_nbrs[nb[k]]++;
                        else if (!v && up_nbrs[nb[k]] > 3'd0)
                            up_nbrs[nb[k]]--;
                    post = is_live(idx);
                    for (int k = 0; k < 4; k++) post += is_live(nb[k]);
                    live_cells = live_cells + post - pre;
                    up_cells = v ? up_cells + 1 : up_cells - 1;
                end
            end
            if (res.bad)
            begin
                res.row = '0;
                res.col = '0;
                res.val = 1'b0;
            end
        end
        res.act   = 13'(live_cells);
        res.occ   = 13'(up_cells);
        res.empty = (live_cells == 0);
        return res;
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                expected_res.push_back(flip_step(flip_req_t'({s_tuser, s_tdata[11:0],
                                                              s_tdata[14:12]})));
            if (pending_reqs.size() > 0 && !(idle_on && $urandom_range(0, 99) < 35))
            begin
                flip_req_t q;
                q = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= q.op;
                s_tdata  <= {1'b0, q.draw, q.pick};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            flip_res_t got, want;
            got = flip_res_t'({m_tuser, m_tdata});
            if (expected_res.size() == 0)
            begin
                $display("%0t: unexpected beat %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_res.pop_front();
                if (got.row != want.row)
                    $display("%0t: cell_row exp %0d got %0d", $time, want.row, got.row);
                if (got.col != want.col)
                    $display("%0t: cell_col exp %0d got %0d", $time, want.col, got.col);
                if (got.val != want.val)
                    $display("%0t: new_value exp %0d got %0d", $time, want.val, got.val);
                if (got.act != want.act)
                    $display("%0t: active_total exp %0d got %0d", $time, want.act, got.act);
                if (got.occ != want.occ)
                    $display("%0t: occupied_total exp %0d got %0d", $time, want.occ,
                             got.occ);
                if (got.empty != want.empty)
                    $display("%0t: now_empty exp %0d got %0d", $time, want.empty,
                             got.empty);
                if (got.bad != want.bad)
                    $display("%0t: bad_pick exp %0d got %0d", $time, want.bad, got.bad);
                if (got != want) errors++;
            end
        end
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_done != hold_reqs)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_done + 1;
        end
        else
            m_tready <= !(idle_on && $urandom_range(0, 99) < 35);
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_res.size() > 0)
            @(posedge clk);
        repeat (160) @(posedge clk);
    endtask

    task automatic write_side(logic [6:0] s);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_GRID_SIDE;
        pwdata  <= {$urandom_range(0, 1) ? 25'h1ffffff : 25'h0, s};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        side_reg = s;
        reseed_grid();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push(logic op, int pick, int draw);
        pending_reqs.push_back(flip_req_t'({op, 12'(pick), 3'(draw)}));
    endtask

    task automatic random_run(int count);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            while (pending_reqs.size() >= 2) @(posedge clk);
            roll = $urandom_range(0, 99);
            if (live_cells == 0 && roll < 70)
                push(OP_RESTART, $urandom_range(0, 4095), $urandom_range(0, 7));
            else if (roll < (eff_side() > 16 ? 1 : 5))
                push(OP_RESTART, $urandom_range(0, 4095), $urandom_range(0, 7));
            else if (roll < 15)
                push(OP_FLIP, $urandom_range(0, 4095), $urandom_range(0, 7));
            else
                push(OP_FLIP, $urandom_range(0, live_cells > 0 ? live_cells : 0),
                     $urandom_range(0, 9) == 0 ? $urandom_range(0, 7)
                                               : $urandom_range(1, 4));
        end
    endtask

    initial
    begin
        logic [6:0] sides[9];
        sides = '{7'd3, 7'd64, 7'd0, 7'd127, 7'd5, 7'd8, 7'd65, 7'd2, 7'd12};
        errors = 0;
        hold_reqs = 0;
        hold_done = 0;
        hold_left = 0;
        quiet_cycles = 0;
        idle_on = 1;
        side_reg = SIDE_RESET;
        reseed_grid();
        rst_n <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        paddr <= '0; pwdata <= '0;
        s_tvalid <= 1'b0; s_tdata <= '0; s_tuser <= 1'b0;
        m_tready <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset grid, side 32: ranks 0..4 are the plus shape around the centre
        push(OP_FLIP, 2, 0);        // centre stays up
        push(OP_FLIP, 0, 1);        // top arm comes up
        push(OP_FLIP, 4095, 4);     // past the live count
        push(OP_FLIP, 0, 7);        // rank 0 is now the cell above the top arm, which stays down
        push(OP_FLIP, 1, 5);
        push(OP_RESTART, 4095, 7);  // restart while live
        push(OP_FLIP, 2, 1);        // centre dies, grid empty
        push(OP_FLIP, 0, 1);        // empty grid gives bad pick
        push(OP_RESTART, 0, 0);
        push(OP_FLIP, 3, 4);
        push(OP_FLIP, 4, 3);
        drain();
        write_side(7'd64);
        push(OP_FLIP, 4, 1);        // bottom arm comes up
        push(OP_FLIP, 0, 0);
        push(OP_FLIP, 5, 2);
        drain();

        foreach (sides[p])
        begin
            write_side(sides[p]);
            idle_on = (p != 4);
            if (p == 5) hold_reqs++;
            random_run(eff_side() > 16 ? 70 : 120);
            drain();
        end
        idle_on = 1;
        random_run(60);
        drain();

        if (errors == 0 && expected_res.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
